FILE: design/nearest_preceding_symbol_lookup_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest preceding symbol lookup
// Shared macros that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PRECEDING_SYMBOL_LOOKUP_DEFINES_SVH
`define NEAREST_PRECEDING_SYMBOL_LOOKUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPSL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/npsl_pkg.sv
// ----------------------------------------------------------------------------
// npsl_pkg
// Types, codes and defaults shared by the symbol lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npsl_pkg;

	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int SEGMENT_SLOTS_DEF = 16;

	// Operation codes carried in the mode field of an input beat.
	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_APPEND = 3'd1;
	localparam logic [2:0] MODE_BASE   = 3'd2;
	localparam logic [2:0] MODE_SEG    = 3'd3;
	localparam logic [2:0] MODE_LIN    = 3'd4;

	// Fixed widths of the result fields.
	localparam int SYM_IDX_W = 10;
	localparam int MSEG_W    = 4;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] segment;
		logic [15:0] offset;
		logic [31:0] linear;
		logic [3:0]  base_index;
		logic [31:0] base_value;
	} in_beat_t;

	typedef struct packed {
		logic                 found;
		logic [SYM_IDX_W-1:0] symbol_index;
		logic [15:0]          distance;
		logic [MSEG_W-1:0]    matched_segment;
		logic                 dropped;
	} out_beat_t;

	typedef logic [3:0] cfg_beat_t;

	// Control from the sequencer to the compare unit.
	typedef struct packed {
		logic clear;
		logic entry_valid;
	} scan_ctrl_t;

endpackage

FILE: design/npsl_chan_if.sv
// ----------------------------------------------------------------------------
// npsl_chan_if
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface npsl_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/nearest_preceding_symbol_lookup.sv
// ----------------------------------------------------------------------------
// nearest_preceding_symbol_lookup
// Symbol table with segment:offset and linear nearest preceding lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block keeps a table of symbol start addresses (segment and offset) in a
// single-port-read RAM and a small register file of linear segment bases. One
// input beat is taken at a time; the input is not ready until its result has
// been placed in the output register, which then waits for the sink on its own.
// Clear, append and base writes go straight from idle to loading their result
// into the output register. A segment lookup walks the whole table through the
// one RAM read port and one shared compare unit, and skips the walk when the
// table is empty. A linear lookup tries segments one by one from 1 upwards and
// walks the table for each segment whose window holds the address, up to the
// first hit. A sink that holds off the full output register stalls the block.
// After reset the table is empty and every segment base is zero, meaning unused.
module nearest_preceding_symbol_lookup #(
	parameter int TABLE_DEPTH   = npsl_pkg::TABLE_DEPTH_DEF,
	parameter int SEGMENT_SLOTS = npsl_pkg::SEGMENT_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	npsl_chan_if.sink   in_ch,
	npsl_chan_if.source out_ch,
	npsl_chan_if.sink   cfg_ch
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SEG_W = $clog2(SEGMENT_SLOTS);
	localparam int SC_W  = SEG_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;

	// Architectural state.
	logic [CNT_W-1:0] count_q;
	logic [3:0]       limit_q;
	logic [31:0]      bases_q [SEGMENT_SLOTS];

	// Working registers of the current operation.
	logic [31:0]      lin_q;
	logic [15:0]      qseg_q;
	logic [15:0]      qoff_q;
	logic             linmode_q;
	logic [SC_W-1:0]  sidx_q;
	logic [IDX_W-1:0] addr_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	npsl_pkg::out_beat_t res_q;
	logic             out_valid_q;
	npsl_pkg::out_beat_t out_data_q;

	// Beat handshakes.
	logic in_fire;
	logic full;
	logic append_ok;
	logic base_ok;
	logic out_load;

	// Linear window check for the segment under test.
	logic        s_ok;
	logic [31:0] cur_base;
	logic [32:0] win_diff;
	logic        win_hit;
	logic        start_scan;
	logic        last_addr;

	// RAM and compare unit wiring.
	logic [31:0] rd_data;
	logic        scan_hit;
	logic [IDX_W-1:0] scan_idx;
	logic [15:0] scan_dist;
	logic [IDX_W+npsl_pkg::SYM_IDX_W-1:0] idx_ext;
	npsl_pkg::scan_ctrl_t scan_ctrl;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign in_fire      = in_ch.valid && in_ch.ready;

	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign append_ok = in_fire && (in_ch.data.mode == npsl_pkg::MODE_APPEND) && !full;
	assign base_ok   = in_fire && (in_ch.data.mode == npsl_pkg::MODE_BASE)
		&& ({1'b0, in_ch.data.base_index} < 5'(SEGMENT_SLOTS));

	// Segment zero is never tried; the counter starts at one and stops past the limit or the last slot.
	assign s_ok     = (5'(sidx_q) <= 5'(limit_q)) && (sidx_q < SC_W'(SEGMENT_SLOTS));
	assign cur_base = bases_q[sidx_q[SEG_W-1:0]];
	// The offset is formed with a borrow bit, so an address below the base never wraps into the window.
	assign win_diff = {1'b0, lin_q} - {1'b0, cur_base};
	assign win_hit  = (cur_base != 32'd0) && !win_diff[32] && (win_diff[31:16] == 16'd0);

	assign start_scan = (in_fire && (in_ch.data.mode == npsl_pkg::MODE_SEG))
		|| ((state_q == ST_WIN) && s_ok && win_hit);
	assign last_addr  = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);

	assign scan_ctrl.clear       = start_scan;
	assign scan_ctrl.entry_valid = vld_s1;

	assign idx_ext  = {{npsl_pkg::SYM_IDX_W{1'b0}}, scan_idx};
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	npsl_sym_ram #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (append_ok),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({in_ch.data.segment, in_ch.data.offset}),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	npsl_scan_unit #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.query_seg (qseg_q),
		.query_off (qoff_q),
		.entry_seg (rd_data[31:16]),
		.entry_off (rd_data[15:0]),
		.entry_idx (idx_s1),
		.hit       (scan_hit),
		.near_idx  (scan_idx),
		.best_dist (scan_dist)
	);

	// Table fill count, configuration register and segment base registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			limit_q <= '0;
			for (int i = 0; i < SEGMENT_SLOTS; i++) begin
				bases_q[i] <= '0;
			end
		end else begin
			if (cfg_ch.valid) begin
				limit_q <= cfg_ch.data;
			end
			if (in_fire && (in_ch.data.mode == npsl_pkg::MODE_CLEAR)) begin
				count_q <= '0;
			end else if (append_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (base_ok) begin
				bases_q[in_ch.data.base_index[SEG_W-1:0]] <= in_ch.data.base_value;
			end
		end
	end

	// Sequencer: drives the table walk, the segment search and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			linmode_q   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			idx_s1 <= addr_q;

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res_q;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						addr_q <= '0;
						case (in_ch.data.mode)
							npsl_pkg::MODE_APPEND: begin
								res_q   <= '{found: 1'b0, symbol_index: '0, distance: '0,
									matched_segment: '0, dropped: full};
								state_q <= ST_FIN;
							end
							npsl_pkg::MODE_SEG: begin
								res_q     <= '0;
								qseg_q    <= in_ch.data.segment;
								qoff_q    <= in_ch.data.offset;
								linmode_q <= 1'b0;
								state_q   <= (count_q == '0) ? ST_DRAIN : ST_SCAN;
							end
							npsl_pkg::MODE_LIN: begin
								res_q     <= '0;
								lin_q     <= in_ch.data.linear;
								sidx_q    <= SC_W'(1);
								linmode_q <= 1'b1;
								state_q   <= ST_WIN;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_WIN: begin
					if (!s_ok) begin
						state_q <= ST_FIN;
					end else if (win_hit) begin
						qseg_q  <= 16'(sidx_q);
						qoff_q  <= win_diff[15:0];
						addr_q  <= '0;
						state_q <= (count_q == '0) ? ST_DRAIN : ST_SCAN;
					end else begin
						sidx_q <= sidx_q + SC_W'(1);
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + IDX_W'(1);
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The compare of the last entry follows its registered read.
					if (!vld_s1) begin
						if (scan_hit) begin
							res_q   <= '{found: 1'b1,
								symbol_index: idx_ext[npsl_pkg::SYM_IDX_W-1:0],
								distance: scan_dist,
								matched_segment: linmode_q ? npsl_pkg::MSEG_W'(sidx_q) : '0,
								dropped: 1'b0};
							state_q <= ST_FIN;
						end else if (linmode_q) begin
							sidx_q  <= sidx_q + SC_W'(1);
							state_q <= ST_WIN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule

FILE: design/npsl_sym_ram.sv
// ----------------------------------------------------------------------------
// npsl_sym_ram
// Symbol table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npsl_sym_ram #(
	parameter int DEPTH = npsl_pkg::TABLE_DEPTH_DEF,
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [31:0]      wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [31:0]      rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/npsl_scan_unit.sv
// ----------------------------------------------------------------------------
// npsl_scan_unit
// Shared compare unit: tracks the closest preceding entry over a table scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npsl_scan_unit #(
	parameter int IDX_W = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  npsl_pkg::scan_ctrl_t ctrl,
	input  logic [15:0]         query_seg,
	input  logic [15:0]         query_off,
	input  logic [15:0]         entry_seg,
	input  logic [15:0]         entry_off,
	input  logic [IDX_W-1:0]    entry_idx,
	output logic                hit,
	output logic [IDX_W-1:0]    near_idx,
	output logic [15:0]         best_dist
);

	logic        hit_q;
	logic [IDX_W-1:0] near_idx_q;
	logic [15:0] best_dist_q;
	logic [15:0] delta;
	logic        take;

	// Only a strictly closer entry replaces the held one, so the earliest wins a tie.
	assign delta = query_off - entry_off;
	assign take = ctrl.entry_valid && (entry_seg == query_seg) && (entry_off <= query_off)
		&& (!hit_q || (delta < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clear) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctrl.clear && take) begin
			near_idx_q  <= entry_idx;
			best_dist_q <= delta;
		end
	end

	assign hit       = hit_q;
	assign near_idx  = near_idx_q;
	assign best_dist = best_dist_q;

endmodule

FILE: design/npsl_checker.sv
// ----------------------------------------------------------------------------
// npsl_checker
// Port-level checks on the symbol lookup block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_preceding_symbol_lookup_defines.svh"

module npsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [9:0]  symbol_index,
	input logic [15:0] distance,
	input logic [3:0]  matched_segment,
	input logic        dropped
);

	// A result beat held back by the sink stays valid and keeps its found flag, position and distance.
	`NPSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol_index) && $stable(distance) && $stable(found), "result beat changed while stalled")

	// A miss reports no position, distance or segment.
	`NPSL_ASSERT_SAME(a_miss_zero, out_valid && !found, symbol_index == 10'd0 && distance == 16'd0 && matched_segment == 4'd0, "miss carries non-zero fields")

	// A refused append is never a lookup hit.
	`NPSL_ASSERT_SAME(a_drop_excl, out_valid && dropped, !found, "dropped and found together")

	// Only one operation is in flight: the input closes after each accepted beat.
	`NPSL_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready, "input accepted twice in a row")

endmodule

bind nearest_preceding_symbol_lookup npsl_checker u_npsl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.found           (out_ch.data.found),
	.symbol_index    (out_ch.data.symbol_index),
	.distance        (out_ch.data.distance),
	.matched_segment (out_ch.data.matched_segment),
	.dropped         (out_ch.data.dropped)
);
